### design/dcot_pkg.sv
// ----------------------------------------------------------------------------
// dcot_pkg
// Shared constants and types for the DC offset tracking block.
// ----------------------------------------------------------------------------
`default_nettype none

package dcot_pkg;

  localparam int BURST_SAMPLES = 156;
  localparam int WINDOW_LOG2   = 7;
  localparam int NUM_CARRIERS  = 4;
  localparam int NUM_ENTRIES   = 32;

  localparam int SampleW   = 16;
  localparam int OffsetW   = 24;
  localparam int SumW      = 24;
  localparam int MeanW     = 17;
  localparam int PosW      = 8;
  localparam int FracShift = 8;
  localparam int SmoothShift = 4;
  localparam int AccW      = 29;

  localparam int TableDepth = 2 * NUM_CARRIERS * NUM_ENTRIES;
  localparam int AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  localparam int WinLen   = 1 << WINDOW_LOG2;
  localparam int WinStart = (BURST_SAMPLES >= WinLen) ? (BURST_SAMPLES - WinLen) / 2 : 0;
  localparam int WinEnd   = WinStart + WinLen;
  localparam int PosMax   = (1 << PosW) - 1;

  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_CORRECT = 1'b1
  } op_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_OFFSET = 1'b1
  } kind_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic                      en;
    logic [AddrW-1:0]          addr;
    logic signed [OffsetW-1:0] data_i;
    logic signed [OffsetW-1:0] data_q;
  } tbl_wr_t;

endpackage

`default_nettype wire

### design/dc_offset_track_and_remove_unit.sv
// ----------------------------------------------------------------------------
// dc_offset_track_and_remove_unit
// DC offset estimation over measure bursts and removal on corrected samples.
//
// Channel  Dir  tdata (low bit up)                              tuser  tlast
// s_axis   in   sample_i, sample_q, carrier, entry, group_seven  op     last
// m_axis   out  out_i, out_q, offset_i, offset_q                 kind   burst_end
//
// One beat is taken every cycle while the output is not stalled. A sample
// passes through the table read stage and the update stage before reaching
// the output register. The offset memory has one read and one write port; a
// write is forwarded to a read of the same entry.
// Reset clears the sums, the position and the entry valid bits at once.
// A stalled output holds the update stage, which in turn holds the input.
// ----------------------------------------------------------------------------
`default_nettype none

module dc_offset_track_and_remove_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // sample_i[15:0], sample_q[31:16], carrier[33:32], entry[38:34],
  // group_seven[39]
  input  wire logic [39:0] s_axis_tdata,
  // op[0]
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_i[15:0], out_q[31:16], offset_i[55:32], offset_q[79:56]
  output logic [79:0]      m_axis_tdata,
  // result_kind[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);
  import dcot_pkg::*;

  logic                       in_acc;
  logic signed [SampleW-1:0]  in_si, in_sq;
  logic [1:0]                 in_carrier;
  logic [4:0]                 in_entry;
  logic                       in_grp;
  op_e                        in_op;
  logic                       in_range;
  int                         idx_int;
  logic [AddrW-1:0]           in_addr;
  logic signed [MeanW-1:0]    mean_i, mean_q;
  tbl_rd_t                    tbl_rd;
  tbl_wr_t                    tbl_wr;
  logic signed [OffsetW-1:0]  old_i_raw, old_q_raw;
  logic signed [OffsetW-1:0]  old_i, old_q;

  logic                       s1_valid_q;
  op_e                        s1_op_q;
  logic                       s1_last_q;
  logic                       s1_range_q;
  logic [AddrW-1:0]           s1_addr_q;
  logic signed [SampleW-1:0]  s1_si_q, s1_sq_q;
  logic signed [MeanW-1:0]    s1_mean_i_q, s1_mean_q_q;
  logic                       s1_adv;
  logic                       s1_has_res;

  logic signed [SampleW:0]    diff_i, diff_q;
  logic signed [SampleW-1:0]  corr_i, corr_q;
  logic signed [AccW-1:0]     acc_i, acc_q;
  logic signed [OffsetW-1:0]  new_i, new_q;

  logic                       m_valid_q, m_valid_d;
  logic                       m_kind_q;
  logic                       m_last_q;
  logic [79:0]                m_data_q;

  assign in_si      = s_axis_tdata[15:0];
  assign in_sq      = s_axis_tdata[31:16];
  assign in_carrier = s_axis_tdata[33:32];
  assign in_entry   = s_axis_tdata[38:34];
  assign in_grp     = s_axis_tdata[39];
  assign in_op      = op_e'(s_axis_tuser);

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_range = (int'(in_carrier) < NUM_CARRIERS) && (int'(in_entry) < NUM_ENTRIES);
  assign idx_int  = (int'(in_grp) * NUM_CARRIERS + int'(in_carrier)) * NUM_ENTRIES
                    + int'(in_entry);
  assign in_addr  = idx_int[AddrW-1:0];

  dcot_accum u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (in_acc && (in_op == OP_MEASURE)),
    .last_i     (s_axis_tlast),
    .sample_i_i (in_si),
    .sample_q_i (in_sq),
    .mean_i_o   (mean_i),
    .mean_q_o   (mean_q)
  );

  assign tbl_rd.en   = in_acc;
  assign tbl_rd.addr = in_addr;

  dcot_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_i    (tbl_rd),
    .wr_i    (tbl_wr),
    .old_i_o (old_i_raw),
    .old_q_o (old_q_raw)
  );

  assign s1_has_res    = (s1_op_q == OP_CORRECT) || s1_last_q;
  assign s1_adv        = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_comb begin
    old_i = s1_range_q ? old_i_raw : '0;
    old_q = s1_range_q ? old_q_raw : '0;

    diff_i = {s1_si_q[SampleW-1], s1_si_q} - (SampleW+1)'(old_i >>> FracShift);
    diff_q = {s1_sq_q[SampleW-1], s1_sq_q} - (SampleW+1)'(old_q >>> FracShift);
    corr_i = diff_i[SampleW-1:0];
    corr_q = diff_q[SampleW-1:0];
    if (diff_i[SampleW] != diff_i[SampleW-1]) begin
      corr_i = diff_i[SampleW] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end
    if (diff_q[SampleW] != diff_q[SampleW-1]) begin
      corr_q = diff_q[SampleW] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end

    acc_i = (AccW'(old_i) <<< SmoothShift) - AccW'(old_i) + (AccW'(s1_mean_i_q) <<< FracShift);
    acc_q = (AccW'(old_q) <<< SmoothShift) - AccW'(old_q) + (AccW'(s1_mean_q_q) <<< FracShift);
    new_i = acc_i[OffsetW+SmoothShift-1:SmoothShift];
    new_q = acc_q[OffsetW+SmoothShift-1:SmoothShift];
  end

  assign tbl_wr.en     = s1_adv && (s1_op_q == OP_MEASURE) && s1_last_q && s1_range_q;
  assign tbl_wr.addr   = s1_addr_q;
  assign tbl_wr.data_i = new_i;
  assign tbl_wr.data_q = new_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= in_op;
      s1_last_q   <= s_axis_tlast;
      s1_range_q  <= in_range;
      s1_addr_q   <= in_addr;
      s1_si_q     <= in_si;
      s1_sq_q     <= in_sq;
      s1_mean_i_q <= mean_i;
      s1_mean_q_q <= mean_q;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (s1_adv) begin
      m_valid_d = s1_has_res;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_has_res) begin
      m_last_q <= s1_last_q;
      if (s1_op_q == OP_CORRECT) begin
        m_kind_q <= KIND_SAMPLE;
        m_data_q <= {48'b0, corr_q, corr_i};
      end else begin
        m_kind_q <= KIND_OFFSET;
        m_data_q <= {new_q, new_i, 32'b0};
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

### design/dcot_accum.sv
// ----------------------------------------------------------------------------
// dcot_accum
// Window accumulator: sums the centred window of a measure burst and gives
// the rounded mean on the final sample.
// ----------------------------------------------------------------------------
`default_nettype none

module dcot_accum (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  last_i,
  input  wire logic signed [dcot_pkg::SampleW-1:0]   sample_i_i,
  input  wire logic signed [dcot_pkg::SampleW-1:0]   sample_q_i,
  output logic signed [dcot_pkg::MeanW-1:0]          mean_i_o,
  output logic signed [dcot_pkg::MeanW-1:0]          mean_q_o
);
  import dcot_pkg::*;

  logic signed [SumW-1:0] sum_i_q, sum_i_d;
  logic signed [SumW-1:0] sum_q_q, sum_q_d;
  logic [PosW-1:0]        pos_q, pos_d;
  logic                   in_win;
  logic signed [SumW-1:0] tot_i, tot_q;
  logic signed [SumW:0]   rnd_i, rnd_q;

  assign in_win = ({1'b0, pos_q} >= (PosW+1)'(WinStart)) &&
                  ({1'b0, pos_q} <  (PosW+1)'(WinEnd));

  always_comb begin
    tot_i = sum_i_q;
    tot_q = sum_q_q;
    if (in_win) begin
      tot_i = sum_i_q + SumW'(sample_i_i);
      tot_q = sum_q_q + SumW'(sample_q_i);
    end
    rnd_i = {tot_i[SumW-1], tot_i} + (SumW+1)'(1 << (WINDOW_LOG2 - 1));
    rnd_q = {tot_q[SumW-1], tot_q} + (SumW+1)'(1 << (WINDOW_LOG2 - 1));
    mean_i_o = MeanW'(rnd_i >>> WINDOW_LOG2);
    mean_q_o = MeanW'(rnd_q >>> WINDOW_LOG2);
  end

  always_comb begin
    sum_i_d = sum_i_q;
    sum_q_d = sum_q_q;
    pos_d   = pos_q;
    if (en_i) begin
      if (last_i) begin
        sum_i_d = '0;
        sum_q_d = '0;
        pos_d   = '0;
      end else begin
        sum_i_d = tot_i;
        sum_q_d = tot_q;
        if (pos_q != PosW'(PosMax)) begin
          pos_d = pos_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_i_q <= '0;
      sum_q_q <= '0;
      pos_q   <= '0;
    end else begin
      sum_i_q <= sum_i_d;
      sum_q_q <= sum_q_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

### design/dcot_table.sv
// ----------------------------------------------------------------------------
// dcot_table
// Offset table: one synchronous memory holding the I and Q offsets, with
// per-entry valid bits so that entries read as zero after reset, and
// forwarding of the most recent write.
// ----------------------------------------------------------------------------
`default_nettype none

module dcot_table (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire dcot_pkg::tbl_rd_t                    rd_i,
  input  wire dcot_pkg::tbl_wr_t                    wr_i,
  output logic signed [dcot_pkg::OffsetW-1:0]       old_i_o,
  output logic signed [dcot_pkg::OffsetW-1:0]       old_q_o
);
  import dcot_pkg::*;

  logic [2*OffsetW-1:0] mem [TableDepth];
  logic [2*OffsetW-1:0] rdata_q;
  logic [AddrW-1:0]     rd_addr_q;
  logic [TableDepth-1:0] valid_q;
  logic                 fwd_vld_q;
  logic [AddrW-1:0]     fwd_addr_q;
  logic [2*OffsetW-1:0] fwd_data_q;
  logic [2*OffsetW-1:0] sel;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= {wr_i.data_q, wr_i.data_i};
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_addr_q <= rd_i.addr;
    end
    if (wr_i.en) begin
      fwd_addr_q <= wr_i.addr;
      fwd_data_q <= {wr_i.data_q, wr_i.data_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      fwd_vld_q <= 1'b0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
      fwd_vld_q          <= 1'b1;
    end
  end

  always_comb begin
    if (fwd_vld_q && (fwd_addr_q == rd_addr_q)) begin
      sel = fwd_data_q;
    end else if (valid_q[rd_addr_q]) begin
      sel = rdata_q;
    end else begin
      sel = '0;
    end
    old_i_o = sel[OffsetW-1:0];
    old_q_o = sel[2*OffsetW-1:OffsetW];
  end

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// DC offset tracking and removal testbench
// Streams measure bursts and corrected samples into the block and checks every
// output beat against an internal predictor of the offset tables, the window
// sums and the burst position. It runs through several idling phases, a long
// output hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dcot_pkg::*;

  localparam int SMOOTH_KEEP    = 15;
  localparam int BEATS_WANTED   = 800;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct {
    op_e                op;
    logic signed [15:0] si;
    logic signed [15:0] sq;
    logic [1:0]         carrier;
    logic [4:0]         entry;
    logic               grp;
    logic               last;
  } sample_beat_t;

  typedef struct {
    kind_e              kind;
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic signed [23:0] offset_i;
    logic signed [23:0] offset_q;
    logic               burst_end;
  } dc_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  sample_beat_t beats_to_send[$];
  dc_result_t   results_due[$];
  sample_beat_t beat_on_bus;

  logic signed [23:0] ofs_i_mem [TableDepth];
  logic signed [23:0] ofs_q_mem [TableDepth];
  logic signed [23:0] win_sum_i = '0;
  logic signed [23:0] win_sum_q = '0;
  logic [7:0]         burst_pos = '0;

  int total_beats = 0;
  int sent_cnt = 0;
  int pause_mark = 0;
  int hold_mark = 0;
  int hold_left = 0;
  bit rx_hold_done = 1'b0;
  int cycle_cnt = 0;
  int n_errors = 0;
  int n_corrected = 0;
  int n_offsets = 0;

  dc_offset_track_and_remove_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int spread(int noise);
    return int'($urandom_range(0, 2 * noise)) - noise;
  endfunction

  // Correct beats subtract the integer part of the stored offset; measure beats
  // build the window sums and, on the last beat, smooth the selected entry.
  task automatic track_and_correct(input sample_beat_t b);
    dc_result_t r;
    int         idx;
    longint     old_i, old_q, mean_i, mean_q, new_i, new_q;
    idx = (int'(b.grp) * NUM_CARRIERS + int'(b.carrier)) * NUM_ENTRIES + int'(b.entry);
    old_i = ofs_i_mem[idx];
    old_q = ofs_q_mem[idx];
    r.kind = KIND_SAMPLE;
    r.out_i = '0;
    r.out_q = '0;
    r.offset_i = '0;
    r.offset_q = '0;
    r.burst_end = b.last;
    if (b.op == OP_CORRECT) begin
      r.out_i = clip16(longint'(b.si) - (old_i >>> FracShift));
      r.out_q = clip16(longint'(b.sq) - (old_q >>> FracShift));
      results_due.push_back(r);
      return;
    end
    if (int'(burst_pos) >= WinStart && int'(burst_pos) < WinEnd) begin
      win_sum_i = win_sum_i + b.si;
      win_sum_q = win_sum_q + b.sq;
    end
    if (burst_pos != 8'(PosMax)) burst_pos = burst_pos + 8'd1;
    if (!b.last) return;
    mean_i = (longint'(win_sum_i) + (longint'(1) << (WINDOW_LOG2 - 1))) >>> WINDOW_LOG2;
    mean_q = (longint'(win_sum_q) + (longint'(1) << (WINDOW_LOG2 - 1))) >>> WINDOW_LOG2;
    new_i = (SMOOTH_KEEP * old_i + (mean_i <<< FracShift)) >>> SmoothShift;
    new_q = (SMOOTH_KEEP * old_q + (mean_q <<< FracShift)) >>> SmoothShift;
    ofs_i_mem[idx] = 24'(new_i);
    ofs_q_mem[idx] = 24'(new_q);
    win_sum_i = '0;
    win_sum_q = '0;
    burst_pos = '0;
    r.kind = KIND_OFFSET;
    r.offset_i = 24'(new_i);
    r.offset_q = 24'(new_q);
    r.burst_end = 1'b1;
    results_due.push_back(r);
  endtask

  task automatic add_beat(op_e op, int si, int sq, int c, int e, int g, bit last);
    sample_beat_t b;
    b.op = op;
    b.si = 16'(si);
    b.sq = 16'(sq);
    b.carrier = 2'(c);
    b.entry = 5'(e);
    b.grp = 1'(g);
    b.last = last;
    beats_to_send.push_back(b);
  endtask

  // A measure burst around a DC level, with correct beats mixed in at random.
  task automatic add_burst(int len, int c, int e, int g, int dc_i, int dc_q, int noise,
                           int mix_pct);
    int k;
    for (k = 0; k < len; k++) begin
      if (k != len - 1 && $urandom_range(0, 99) < mix_pct)
        add_beat(OP_CORRECT, int'($urandom) % 65536 - 32768, int'($urandom) % 65536 - 32768,
                 $urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 1),
                 1'($urandom_range(0, 1)));
      add_beat(OP_MEASURE, clamp16(dc_i + spread(noise)), clamp16(dc_q + spread(noise)),
               c, e, g, k == len - 1);
    end
  endtask

  function automatic int pick_level();
    case ($urandom_range(0, 3))
      0: return 32767;
      1: return -32768;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  always @(posedge clk_i) begin
    int accepted;
    int phase;
    int idle_pct;
    bit fire;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        track_and_correct(beat_on_bus);
        sent_cnt <= sent_cnt + 1;
      end
      accepted = sent_cnt + int'(fire);
      phase = (accepted * 4) / total_beats;
      idle_pct = (phase == 1) ? 48 : (phase == 3) ? 21 : 0;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
            !(accepted == pause_mark && results_due.size() != 0)) begin
          beat_on_bus = beats_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {beat_on_bus.grp, beat_on_bus.entry, beat_on_bus.carrier,
                           beat_on_bus.sq, beat_on_bus.si};
          s_axis_tuser <= beat_on_bus.op;
          s_axis_tlast <= beat_on_bus.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!rx_hold_done && sent_cnt >= hold_mark) begin
      hold_left <= RX_HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end
  end

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    int         phase;
    int         stall_pct;
    dc_result_t want;
    dc_result_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.out_i = m_axis_tdata[15:0];
        got.out_q = m_axis_tdata[31:16];
        got.offset_i = m_axis_tdata[55:32];
        got.offset_q = m_axis_tdata[79:56];
        got.burst_end = m_axis_tlast;
        if (results_due.size() == 0) begin
          $error("output beat with no result outstanding");
          n_errors++;
        end else begin
          want = results_due.pop_front();
          compare_field("result_kind", want.kind, got.kind);
          compare_field("out_i", want.out_i, got.out_i);
          compare_field("out_q", want.out_q, got.out_q);
          compare_field("offset_i", want.offset_i, got.offset_i);
          compare_field("offset_q", want.offset_q, got.offset_q);
          compare_field("burst_end", want.burst_end, got.burst_end);
          if (want.kind == KIND_OFFSET) n_offsets++;
          else n_corrected++;
        end
      end
      phase = (sent_cnt * 4) / total_beats;
      stall_pct = (phase == 2) ? 48 : (phase == 3) ? 21 : 0;
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int sel;
    int c, e, g;
    int last_c, last_e, last_g;
    int k, n;
    for (k = 0; k < TableDepth; k++) begin
      ofs_i_mem[k] = '0;
      ofs_q_mem[k] = '0;
    end

    // Directed: extremes on cleared entries, a one-beat burst, then a short
    // burst that pushes an entry far enough to saturate corrected samples.
    add_beat(OP_CORRECT, 32767, -32768, 3, 31, 1, 1'b1);
    add_beat(OP_CORRECT, -32768, 32767, 0, 0, 0, 1'b0);
    add_beat(OP_MEASURE, -32768, 32767, 2, 17, 1, 1'b1);
    add_burst(20, 1, 5, 0, 32767, -32768, 0, 0);
    add_beat(OP_CORRECT, -32768, 32767, 1, 5, 0, 1'b1);
    add_beat(OP_CORRECT, 32767, -32768, 1, 5, 1, 1'b0);

    // A burst long enough to saturate the position counter.
    add_burst(300, 2, 9, 1, pick_level(), pick_level(), 4000, 0);
    last_c = 2;
    last_e = 9;
    last_g = 1;

    while (beats_to_send.size() < BEATS_WANTED) begin
      sel = $urandom_range(0, 99);
      c = $urandom_range(0, 3);
      e = $urandom_range(0, 31);
      g = $urandom_range(0, 1);
      if (sel < 30) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 1)) begin
            add_beat(OP_CORRECT, pick_level(), pick_level(), last_c, last_e, last_g,
                     1'($urandom_range(0, 1)));
          end else begin
            add_beat(OP_CORRECT, pick_level(), pick_level(), c, e, g,
                     1'($urandom_range(0, 1)));
          end
        end
      end else if (sel < 45) begin
        add_burst($urandom_range(142, 170), c, e, g, pick_level(), pick_level(),
                  $urandom_range(0, 2000), 0);
        add_beat(OP_CORRECT, 32767, -32768, c, e, g, 1'b0);
        add_beat(OP_CORRECT, -32768, 32767, c, e, g, 1'b1);
        last_c = c;
        last_e = e;
        last_g = g;
      end else if (sel < 85) begin
        add_burst($urandom_range(1, 40), c, e, g, 0, 0, 32768, 0);
      end else begin
        add_burst($urandom_range(5, 30), c, e, g, pick_level(), pick_level(), 3000, 30);
      end
    end

    total_beats = beats_to_send.size();
    pause_mark = total_beats / 4 + 5;
    hold_mark = total_beats / 2 + 10;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt != total_beats) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d beats: %0d corrected samples and %0d offset updates checked,",
             total_beats, n_corrected, n_offsets);
    $display("across idle, sender-gap, receiver-stall, hold-off and drain phases.");
    if (n_errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
